### rtl/bfa_pkg.sv
// Shared sizes, codes and interface types of the bitmap frame allocator.
// No dependencies; used by every module of the block.
`default_nettype none

package bfa_pkg;

   // Pool geometry (PAGE_BYTES must be a power of two)
   localparam int FRAME_COUNT = 4096;
   localparam int PAGE_BYTES  = 4096;
   localparam int PAGE_SHIFT  = $clog2(PAGE_BYTES);

   // Bitmap layout: 32 frames per word
   localparam int WORD_COUNT = (FRAME_COUNT + 31) / 32;
   localparam int WORD_IDX_W = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
   localparam int FRAME_W    = WORD_IDX_W + 5;

   localparam logic [WORD_IDX_W-1:0] LAST_WORD_IDX = WORD_IDX_W'(WORD_COUNT - 1);

   // Bits of the last word that lie past the pool read as used
   localparam int TAIL_BITS = FRAME_COUNT - 32 * (WORD_COUNT - 1);
   localparam logic [31:0] TAIL_USED_MASK =
      (TAIL_BITS == 32) ? 32'h0 : ~((32'h1 << TAIL_BITS) - 32'h1);

   localparam logic [31:0] REGION_BASE_RESET = 32'h0100_0000;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_FULL    = 2'd1,
      STATUS_OUTSIDE = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FREE_CHK,
      ST_FREE_WR,
      ST_SCAN,
      ST_DONE
   } state_type;

   // Bitmap memory access from the sequencer
   typedef struct packed {
      logic                  we;
      logic [WORD_IDX_W-1:0] waddr;
      logic [31:0]           wdata;
      logic [WORD_IDX_W-1:0] raddr;
   } mem_req_type;

   // Finished result handed to the output register
   typedef struct packed {
      logic        valid;
      logic [31:0] granted;
      logic [1:0]  status;
   } result_type;

endpackage

`default_nettype wire

### rtl/bitmap_frame_allocator.sv
// Top level of the bitmap frame allocator: CSR, sequencer, bitmap memory,
// response register. Depends on bfa_pkg, bfa_bitmap_mem and bfa_sequencer.
//
// Usage:
//   req_ channel: req_command (0 allocate, 1 free) and req_frame_address.
//   rsp_ channel: rsp_granted_address and rsp_status (0 ok, 1 pool full,
//   2 address outside pool); exactly one response per request, in order.
//   csr_ channel: csr_data sets region_base; write only while idle.
//   One request is worked on at a time; req_ready is high when the
//   sequencer is idle, even while a response still waits in rsp_.
//   Free: read-modify-write of one bitmap word; an address outside the pool
//   skips the write. Allocate: the scan reads one bitmap word per cycle
//   through the single memory read port and ends at the first word with
//   a free bit, or at the last word when the pool is full.
//   Reset clears per-word valid bits, so the pool is empty right after
//   reset with no sweep; region_base returns to 0x1000000.
//   A stalled receiver holds the response in rsp_; the sequencer waits
//   with the next result until the response register is taken.
`default_nettype none

module bitmap_frame_allocator (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_command,
   input  wire logic [31:0] req_frame_address,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_granted_address,
   output logic [1:0]       rsp_status,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [31:0] csr_data
);

   logic [31:0]           region_base_ff;
   logic                  rsp_valid_ff;
   logic [31:0]           rsp_granted_ff;
   logic [1:0]            rsp_status_ff;
   logic                  out_free;
   bfa_pkg::mem_req_type  mem_req;
   logic [31:0]           rd_data;
   bfa_pkg::result_type   result;

   // Region base register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         region_base_ff <= bfa_pkg::REGION_BASE_RESET;
      end else if (csr_valid && csr_ready) begin
         region_base_ff <= csr_data;
      end
   end

   // Sequencer and bitmap
   bfa_sequencer u_seq (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_command       (req_command),
      .req_frame_address (req_frame_address),
      .region_base       (region_base_ff),
      .out_free          (out_free),
      .mem_req           (mem_req),
      .rd_data           (rd_data),
      .result            (result)
   );

   bfa_bitmap_mem u_mem (
      .clock   (clock),
      .reset   (reset),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   // Response register
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= result.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (result.valid) begin
         rsp_granted_ff <= result.granted;
         rsp_status_ff  <= result.status;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_granted_address = rsp_granted_ff;
   assign rsp_status          = rsp_status_ff;

endmodule

`default_nettype wire

### rtl/bfa_bitmap_mem.sv
// Used-bit bitmap storage: one write and one registered read per cycle.
// Per-word valid bits make every word read as zero after reset.
// Depends on bfa_pkg.
`default_nettype none

module bfa_bitmap_mem (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire bfa_pkg::mem_req_type mem_req,
   output logic [31:0]               rd_data
);

   logic [31:0]                     mem [bfa_pkg::WORD_COUNT];
   logic [bfa_pkg::WORD_COUNT-1:0]  valid_ff;
   logic [bfa_pkg::WORD_COUNT-1:0]  valid_in;
   logic [31:0]                     rd_word_ff;
   logic                            rd_valid_ff;

   // Storage array, no reset
   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem[mem_req.waddr] <= mem_req.wdata;
      end
      rd_word_ff <= mem[mem_req.raddr];
   end

   // Valid bits: cleared at once by reset, set by the first write
   always_comb begin
      valid_in = valid_ff;
      if (mem_req.we) begin
         valid_in[mem_req.waddr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         rd_valid_ff <= valid_ff[mem_req.raddr];
      end
   end

   // Never-written word reads as all frames free
   assign rd_data = rd_valid_ff ? rd_word_ff : 32'h0;

endmodule

`default_nettype wire

### rtl/bfa_sequencer.sv
// Request sequencer: word scan for allocate, read-modify-write for free.
// Drives the bitmap memory port and hands one result per request.
// Depends on bfa_pkg.
`default_nettype none

module bfa_sequencer (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic                 req_command,
   input  wire logic [31:0]          req_frame_address,
   input  wire logic [31:0]          region_base,
   input  wire logic                 out_free,
   output bfa_pkg::mem_req_type      mem_req,
   input  wire logic [31:0]          rd_data,
   output bfa_pkg::result_type       result
);

   bfa_pkg::state_type               state_ff, state_in;
   logic [31:0]                      offset_ff;
   logic [bfa_pkg::WORD_IDX_W-1:0]   rd_ptr_ff;
   logic [bfa_pkg::WORD_IDX_W-1:0]   chk_ptr_ff;
   logic                             data_valid_ff;
   logic [bfa_pkg::FRAME_W-1:0]      frame_ff;
   logic                             alloc_ok_ff;
   bfa_pkg::status_type              status_ff;

   logic                             accept;
   logic [bfa_pkg::FRAME_W-1:0]      tgt_frame;
   logic                             in_range;
   logic [31:0]                      eff_word;
   logic [5:0]                       zpos;
   logic                             hit;
   logic                             miss_last;

   // Lowest clear bit of a word, 32 when the word is full
   function automatic logic [5:0] lowest_zero(input logic [31:0] w);
      logic [5:0] pos;
      pos = 6'd32;
      for (int b = 31; b >= 0; b--) begin
         if (!w[b]) begin
            pos = 6'(b);
         end
      end
      return pos;
   endfunction

   assign accept = req_valid && req_ready;

   // Free path: frame number of the offset, range check
   assign tgt_frame = offset_ff[bfa_pkg::PAGE_SHIFT +: bfa_pkg::FRAME_W];
   assign in_range  = (offset_ff >> bfa_pkg::PAGE_SHIFT) < 32'(bfa_pkg::FRAME_COUNT);

   // Scan path: check the word read in the previous cycle
   assign eff_word  = rd_data |
                      ((chk_ptr_ff == bfa_pkg::LAST_WORD_IDX) ? bfa_pkg::TAIL_USED_MASK : 32'h0);
   assign zpos      = lowest_zero(eff_word);
   assign hit       = data_valid_ff && !zpos[5];
   assign miss_last = data_valid_ff && zpos[5] && (chk_ptr_ff == bfa_pkg::LAST_WORD_IDX);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bfa_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = req_command ? bfa_pkg::ST_FREE_CHK : bfa_pkg::ST_SCAN;
            end
         end
         bfa_pkg::ST_FREE_CHK: begin
            state_in = in_range ? bfa_pkg::ST_FREE_WR : bfa_pkg::ST_DONE;
         end
         bfa_pkg::ST_FREE_WR: begin
            state_in = bfa_pkg::ST_DONE;
         end
         bfa_pkg::ST_SCAN: begin
            if (hit || miss_last) begin
               state_in = bfa_pkg::ST_DONE;
            end
         end
         bfa_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = bfa_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bfa_pkg::ST_IDLE;
         end
      endcase
   end

   // Outputs: handshake, memory port, result
   always_comb begin
      req_ready      = 1'b0;
      mem_req.we     = 1'b0;
      mem_req.waddr  = chk_ptr_ff;
      mem_req.wdata  = rd_data;
      mem_req.raddr  = rd_ptr_ff;
      result.valid   = 1'b0;
      result.granted = 32'h0;
      result.status  = status_ff;
      case (state_ff)
         bfa_pkg::ST_IDLE: begin
            req_ready = 1'b1;
         end
         bfa_pkg::ST_FREE_CHK: begin
            mem_req.raddr = tgt_frame[bfa_pkg::FRAME_W-1:5];
         end
         bfa_pkg::ST_FREE_WR: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = tgt_frame[bfa_pkg::FRAME_W-1:5];
            mem_req.wdata = rd_data & ~(32'h1 << tgt_frame[4:0]);
         end
         bfa_pkg::ST_SCAN: begin
            mem_req.we    = hit;
            mem_req.waddr = chk_ptr_ff;
            mem_req.wdata = rd_data | (32'h1 << zpos[4:0]);
         end
         bfa_pkg::ST_DONE: begin
            result.valid = out_free;
            if (alloc_ok_ff) begin
               result.granted = region_base + (32'(frame_ff) << bfa_pkg::PAGE_SHIFT);
            end
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= bfa_pkg::ST_IDLE;
         data_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (accept) begin
            data_valid_ff <= 1'b0;
         end else if (state_ff == bfa_pkg::ST_SCAN) begin
            data_valid_ff <= 1'b1;
         end
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      if (accept) begin
         offset_ff   <= req_frame_address - region_base;
         rd_ptr_ff   <= '0;
         chk_ptr_ff  <= '0;
         alloc_ok_ff <= 1'b0;
         status_ff   <= bfa_pkg::STATUS_OK;
      end
      case (state_ff)
         bfa_pkg::ST_FREE_CHK: begin
            status_ff <= in_range ? bfa_pkg::STATUS_OK : bfa_pkg::STATUS_OUTSIDE;
         end
         bfa_pkg::ST_SCAN: begin
            // one word read each cycle; the last word is re-read until checked
            chk_ptr_ff <= rd_ptr_ff;
            if (rd_ptr_ff != bfa_pkg::LAST_WORD_IDX) begin
               rd_ptr_ff <= rd_ptr_ff + 1'b1;
            end
            if (hit) begin
               frame_ff    <= {chk_ptr_ff, zpos[4:0]};
               alloc_ok_ff <= 1'b1;
               status_ff   <= bfa_pkg::STATUS_OK;
            end else if (miss_last) begin
               status_ff <= bfa_pkg::STATUS_FULL;
            end
         end
         default: begin
         end
      endcase
   end

   // An accepted request always leaves idle
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != bfa_pkg::ST_IDLE)
      else $error("accepted request did not start work");

   // A grant write during the scan finishes with an ok status
   a_grant_ok: assert property (@(posedge clock) disable iff (reset)
      (mem_req.we && state_ff == bfa_pkg::ST_SCAN) |=>
         (state_ff == bfa_pkg::ST_DONE && status_ff == bfa_pkg::STATUS_OK && alloc_ok_ff))
      else $error("scan write without ok grant");

   // Failed requests return a zero address
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (result.valid && result.status != bfa_pkg::STATUS_OK) |-> result.granted == 32'h0)
      else $error("nonzero address on failed request");

   // Results leave only when the output register can take them
   a_result_free: assert property (@(posedge clock) disable iff (reset)
      result.valid |-> out_free && state_ff == bfa_pkg::ST_DONE)
      else $error("result issued into a full output register");

endmodule

`default_nettype wire

### tb/sv/tb_bitmap_frame_allocator.sv
// Self-checking testbench for bitmap_frame_allocator: a ledger class tracks the used-frame
// bitmap and region_base, predicts each response and checks the responses in order.
// Depends on bfa_pkg and the bitmap_frame_allocator RTL.
`default_nettype none

typedef enum logic {
   CMD_ALLOCATE = 1'b0,
   CMD_FREE     = 1'b1
} command_type;

typedef struct packed {
   logic [31:0]         granted;
   bfa_pkg::status_type status;
} grant_result_type;

// Mirror of the frame pool: bitmap words, region base and the pending responses
class frame_pool_ledger;
   logic [31:0]      used_words [bfa_pkg::WORD_COUNT];
   logic [31:0]      region_base;
   grant_result_type expected_grants [$];
   int               mismatches;

   function new();
      foreach (used_words[w]) used_words[w] = '0;
      region_base = bfa_pkg::REGION_BASE_RESET;
      mismatches  = 0;
   endfunction

   // Predict the response for an accepted request and update the bitmap
   function void note_request(command_type cmd, logic [31:0] addr);
      grant_result_type r;
      logic [31:0]      frame_no;
      bit               found;
      r.granted = '0;
      r.status  = bfa_pkg::STATUS_OK;
      found     = 1'b0;
      if (cmd == CMD_ALLOCATE) begin
         // first fit: lowest clear bit of the lowest word with room
         for (int w = 0; w < bfa_pkg::WORD_COUNT && !found; w++) begin
            if (used_words[w] != '1) begin
               for (int b = 0; b < 32 && !found; b++) begin
                  if (!used_words[w][b] && (w * 32 + b) < bfa_pkg::FRAME_COUNT) begin
                     used_words[w][b] = 1'b1;
                     frame_no  = 32'(w * 32 + b);
                     r.granted = region_base + frame_no * 32'(bfa_pkg::PAGE_BYTES);
                     found     = 1'b1;
                  end
               end
            end
         end
         if (!found) r.status = bfa_pkg::STATUS_FULL;
      end else begin
         // offset wraps modulo 2^32, so addresses below the base land far outside
         frame_no = (addr - region_base) / 32'(bfa_pkg::PAGE_BYTES);
         if (frame_no < 32'(bfa_pkg::FRAME_COUNT))
            used_words[frame_no >> 5][frame_no[4:0]] = 1'b0;
         else
            r.status = bfa_pkg::STATUS_OUTSIDE;
      end
      expected_grants.push_back(r);
   endfunction

   // Compare one response with the oldest prediction
   function void check_response(logic [31:0] granted, logic [1:0] status);
      grant_result_type exp_r;
      if (expected_grants.size() == 0) begin
         mismatches++;
         $display("%0t: response with no request outstanding: expected none, actual %h %0d",
                  $time, granted, status);
         return;
      end
      exp_r = expected_grants.pop_front();
      if (granted !== exp_r.granted) begin
         mismatches++;
         $display("%0t: granted_address mismatch: expected %h actual %h",
                  $time, exp_r.granted, granted);
      end
      if (status !== exp_r.status) begin
         mismatches++;
         $display("%0t: status mismatch: expected %0d actual %0d",
                  $time, exp_r.status, status);
      end
   endfunction
endclass

module tb_bitmap_frame_allocator;

   // a full scan plus stalls is the worst gap; this limit is many times that
   localparam int IDLE_LIMIT       = 5000;
   localparam int DRAIN_CYCLES     = bfa_pkg::WORD_COUNT + 8;
   localparam int RANDOM_PER_PHASE = 240;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_command;
   logic [31:0] req_frame_address;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [31:0] rsp_granted_address;
   logic [1:0]  rsp_status;
   logic        csr_valid;
   logic        csr_ready;
   logic [31:0] csr_data;

   frame_pool_ledger ledger;
   int sender_idle_pct;
   int receiver_stall_pct;
   int idle_cycles;

   bitmap_frame_allocator DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_command         (req_command),
      .req_frame_address   (req_frame_address),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_granted_address (rsp_granted_address),
      .rsp_status          (rsp_status),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_data            (csr_data)
   );

   always #1 clock = ~clock;

   // Response side: check accepted responses, stall at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready)
            ledger.check_response(rsp_granted_address, rsp_status);
         rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // Watchdog: too long without any handshake means a hang
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
                   (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   // Byte address inside a frame at the current base
   function automatic logic [31:0] pool_address(int frame_no, int offset);
      return ledger.region_base + 32'(frame_no) * 32'(bfa_pkg::PAGE_BYTES) + 32'(offset);
   endfunction

   // Send one request; valid drops only during a random gap
   task automatic send_request(command_type cmd, logic [31:0] addr);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_command       <= cmd;
      req_frame_address <= addr;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      ledger.note_request(cmd, addr);
   endtask

   // Write region_base once every response is back
   task automatic write_region_base(logic [31:0] value);
      req_valid <= 1'b0;
      while (ledger.expected_grants.size() != 0) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid          <= 1'b0;
      ledger.region_base = value;
   endtask

   // Mostly allocations and in-pool frees, some addresses outside the pool
   task automatic run_random(int count);
      int roll;
      for (int i = 0; i < count; i++) begin
         roll = $urandom_range(99);
         if (roll < 50) begin
            send_request(CMD_ALLOCATE, $urandom());
         end else if (roll < 88) begin
            send_request(CMD_FREE, pool_address($urandom_range(bfa_pkg::FRAME_COUNT - 1),
                                                $urandom_range(bfa_pkg::PAGE_BYTES - 1)));
         end else begin
            case ($urandom_range(2))
               0: begin
                  send_request(CMD_FREE, $urandom());
               end
               1: begin
                  send_request(CMD_FREE, ledger.region_base - 32'($urandom_range(1, 1 << 20)));
               end
               default: begin
                  send_request(CMD_FREE, pool_address(bfa_pkg::FRAME_COUNT,
                                                      $urandom_range(1 << 20)));
               end
            endcase
         end
      end
   endtask

   initial begin
      clock              = 1'b0;
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_command        = 1'b0;
      req_frame_address  = '0;
      rsp_ready          = 1'b0;
      csr_valid          = 1'b0;
      csr_data           = '0;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      ledger             = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset base, first fit, frees inside and outside the pool
      send_request(CMD_ALLOCATE, 32'h0000_0000);
      send_request(CMD_ALLOCATE, 32'hFFFF_FFFF);
      send_request(CMD_ALLOCATE, 32'h5A5A_A5A5);
      send_request(CMD_FREE, pool_address(1, 'h123));
      send_request(CMD_ALLOCATE, 32'h0);
      send_request(CMD_FREE, pool_address(5, 0));
      send_request(CMD_FREE, ledger.region_base - 32'd1);
      send_request(CMD_FREE, pool_address(bfa_pkg::FRAME_COUNT, 0));
      send_request(CMD_FREE, pool_address(bfa_pkg::FRAME_COUNT, -1));
      send_request(CMD_FREE, 32'h0000_0000);
      send_request(CMD_FREE, 32'hFFFF_FFFF);
      send_request(CMD_FREE, pool_address(0, 0));
      send_request(CMD_ALLOCATE, 32'h0);

      // Last byte of the last frame, a free of a frame already free
      send_request(CMD_FREE, pool_address(bfa_pkg::FRAME_COUNT - 1, bfa_pkg::PAGE_BYTES - 1));
      send_request(CMD_ALLOCATE, 32'h0);
      send_request(CMD_ALLOCATE, 32'h0);
      send_request(CMD_FREE, pool_address(0, bfa_pkg::PAGE_BYTES / 2));
      send_request(CMD_ALLOCATE, 32'h0);
      run_random(RANDOM_PER_PHASE);

      // Sender gaps, base at the top so granted addresses wrap
      sender_idle_pct = 74;
      write_region_base(32'hFFFF_F000);
      run_random(RANDOM_PER_PHASE);

      // Receiver stalls, base zero
      sender_idle_pct    = 0;
      receiver_stall_pct = 74;
      write_region_base(32'h0000_0000);
      run_random(RANDOM_PER_PHASE);

      // Light gaps on both sides, unaligned bases
      sender_idle_pct    = 11;
      receiver_stall_pct = 11;
      write_region_base(32'hFFFF_FFFF);
      run_random(RANDOM_PER_PHASE / 2);
      write_region_base(32'h0ABC_D123);
      run_random(RANDOM_PER_PHASE / 2);

      // Drain, then watch for stray responses
      req_valid <= 1'b0;
      while (ledger.expected_grants.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (ledger.mismatches == 0 && ledger.expected_grants.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

`default_nettype wire
